// ===== sv/crss_pkg.sv =====
// ----------------------------------------------------------------------------
// crss_pkg
// Shared types and constants for the Catmull-Rom spline sampler: controller
// states, configuration register codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package crss_pkg;

    localparam int T_WIDTH    = 16;
    localparam int SAMPLES_W  = 7;
    localparam int STEP_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int WIN_DEPTH  = 4;
    localparam int SLOT_W     = 2;
    localparam int HELD_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP    = 2'd1;

    localparam logic [SAMPLES_W-1:0] SAMPLES_RST = 7'd50;
    localparam logic [STEP_W-1:0]    STEP_RST    = 15'd1311;
    localparam logic [HELD_W-1:0]    HELD_FULL   = 3'd4;
    localparam logic [HELD_W-1:0]    HELD_RUN    = 3'd3;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic               load;
        logic               shift;
        logic [SLOT_W-1:0]  slot;
        logic               issue;
        logic [T_WIDTH-1:0] t;
        logic               last;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic adv;
    } t_dp_stat;

endpackage

// ===== sv/catmull_rom_spline_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_spline_sampler_unit
// Uniform Catmull-Rom spline sampler: keeps the last four control points of
// a path and emits one run of interpolated samples per point once full.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                      | payload
//  point     | in        | i_point_valid / o_point_ready  | x, y, path_end
//  sample    | out       | o_sample_valid / i_sample_ready| x, y, run_last
//  config    | in        | i_cfg_we                       | index, data
//
//  A point that completes or shifts a full window starts a run of
//  min(samples_per_segment, MAX_SAMPLES) samples, one per cycle while the
//  output is not stalled; points that do not complete the window start no
//  run. Reset is synchronous; sample output stalls freeze the whole Horner
//  pipeline, and the next point is taken once it has drained.
// ----------------------------------------------------------------------------
module catmull_rom_spline_sampler_unit #(
    parameter int MAX_SAMPLES = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [crss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [crss_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_point_valid,
    output logic                                o_point_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_point_x,
    input  logic signed [COORD_WIDTH-1:0]       i_point_y,
    input  logic                                i_point_path_end,
    output logic                                o_sample_valid,
    input  logic                                i_sample_ready,
    output logic signed [COORD_WIDTH-1:0]       o_sample_x,
    output logic signed [COORD_WIDTH-1:0]       o_sample_y,
    output logic                                o_sample_run_last
);
    import crss_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    crss_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_point_valid    (i_point_valid),
        .i_point_path_end (i_point_path_end),
        .o_point_ready    (o_point_ready),
        .o_cmd            (w_cmd),
        .i_stat           (w_stat)
    );

    crss_dpath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_point_x         (i_point_x),
        .i_point_y         (i_point_y),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_sample_ready    (i_sample_ready),
        .o_sample_valid    (o_sample_valid),
        .o_sample_x        (o_sample_x),
        .o_sample_y        (o_sample_y),
        .o_sample_run_last (o_sample_run_last)
    );

endmodule

// ===== sv/crss_ctrl.sv =====
// ----------------------------------------------------------------------------
// crss_ctrl
// Sequencer: configuration registers, window fill count and the sample
// counter and parameter accumulator that drive one run per control point.
// ----------------------------------------------------------------------------
module crss_ctrl #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [crss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [crss_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_point_valid,
    input  logic                                i_point_path_end,
    output logic                                o_point_ready,
    output crss_pkg::t_dp_cmd                   o_cmd,
    input  crss_pkg::t_dp_stat                  i_stat
);
    import crss_pkg::*;

    localparam int NW = $clog2(MAX_SAMPLES + 1);
    localparam logic [SAMPLES_W-1:0] MAX_CNT = SAMPLES_W'(MAX_SAMPLES);

    t_state                r_state, n_state;
    logic [SAMPLES_W-1:0]  r_samples;
    logic [STEP_W-1:0]     r_step;
    logic [HELD_W-1:0]     r_held;
    logic [NW-1:0]         r_k;
    logic [T_WIDTH-1:0]    r_t;
    logic [NW-1:0]         w_n_eff;
    logic                  w_accept;
    logic                  w_run;
    logic                  w_issue;
    logic                  w_is_last;

    assign w_n_eff   = (r_samples > MAX_CNT) ? NW'(MAX_CNT) : NW'(r_samples);
    assign w_accept  = i_point_valid && o_point_ready;
    assign w_run     = (r_held >= HELD_RUN) && (w_n_eff != '0);
    assign w_issue   = (r_state == ST_RUN) && i_stat.adv;
    assign w_is_last = (r_k == w_n_eff - NW'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_run) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_issue && w_is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_point_ready = (r_state == ST_IDLE) && !i_stat.busy;
        o_cmd.load    = w_accept;
        o_cmd.shift   = (r_held == HELD_FULL);
        o_cmd.slot    = r_held[SLOT_W-1:0];
        o_cmd.issue   = w_issue;
        o_cmd.t       = r_t;
        o_cmd.last    = w_is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_samples <= SAMPLES_RST;
            r_step    <= STEP_RST;
            r_held    <= '0;
            r_k       <= '0;
            r_t       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SAMPLES: r_samples <= i_cfg_data[SAMPLES_W-1:0];
                    REG_STEP:    r_step    <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                if (i_point_path_end) begin
                    r_held <= '0;
                end else if (r_held != HELD_FULL) begin
                    r_held <= r_held + HELD_W'(1);
                end
                r_k <= '0;
                r_t <= '0;
            end else if (w_issue) begin
                r_k <= r_k + NW'(1);
                r_t <= r_t + T_WIDTH'(r_step);
            end
        end
    end

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_k < w_n_eff))
        else $error("sample counter past run length");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_is_last) |=> (r_state == ST_IDLE))
        else $error("run did not end after last sample");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_FULL)
        else $error("window fill count out of range");

endmodule

// ===== sv/crss_dpath.sv =====
// ----------------------------------------------------------------------------
// crss_dpath
// Point window, segment coefficients and a four-stage Horner pipeline for x
// and y, ending in the output register. The pipeline stalls as a whole.
// ----------------------------------------------------------------------------
module crss_dpath #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic signed [COORD_WIDTH-1:0]   i_point_x,
    input  logic signed [COORD_WIDTH-1:0]   i_point_y,
    input  crss_pkg::t_dp_cmd               i_cmd,
    output crss_pkg::t_dp_stat              o_stat,
    input  logic                            i_sample_ready,
    output logic                            o_sample_valid,
    output logic signed [COORD_WIDTH-1:0]   o_sample_x,
    output logic signed [COORD_WIDTH-1:0]   o_sample_y,
    output logic                            o_sample_run_last
);
    import crss_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 4;
    localparam int AW = W + 6;
    localparam int PW = AW + T_WIDTH + 1;
    localparam logic signed [PW-1:0] HALF16 = PW'(1) <<< (T_WIDTH - 1);
    localparam logic signed [AW-1:0] SAT_HI = $signed({{(AW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [AW-1:0] SAT_LO = $signed({{(AW-W+1){1'b1}}, {(W-1){1'b0}}});

    logic signed [W-1:0]  r_win [WIN_DEPTH][2];
    logic signed [W-1:0]  n_win [WIN_DEPTH][2];
    logic signed [W-1:0]  w_pin [2];
    logic signed [DW-1:0] w_q   [WIN_DEPTH][2];
    logic signed [DW-1:0] r_a [2], r_b [2], r_c [2], r_d [2];
    logic signed [DW-1:0] n_a [2], n_b [2], n_c [2], n_d [2];

    logic signed [PW-1:0] r_m1 [2], r_m2 [2], r_m3 [2];
    logic signed [AW-1:0] w_acc1 [2], w_acc2 [2], w_acc3 [2], w_half [2];
    logic signed [W-1:0]  w_sat [2];
    logic [T_WIDTH-1:0]   r_t1, r_t2;
    logic signed [T_WIDTH:0] w_tt0, w_tt1, w_tt2;
    logic                 r_v1, r_v2, r_v3, r_ov;
    logic                 r_l1, r_l2, r_l3;
    logic signed [W-1:0]  r_ox, r_oy;
    logic                 r_olast;
    logic                 w_adv;

    assign w_adv       = !r_ov || i_sample_ready;
    assign o_stat.adv  = w_adv;
    assign o_stat.busy = r_v1 || r_v2 || r_v3;

    assign w_pin[0] = i_point_x;
    assign w_pin[1] = i_point_y;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int e = 0; e < WIN_DEPTH - 1; e++) begin
                if (i_cmd.shift) begin
                    n_win[e][l] = r_win[e+1][l];
                end else if (i_cmd.slot == SLOT_W'(e)) begin
                    n_win[e][l] = w_pin[l];
                end else begin
                    n_win[e][l] = r_win[e][l];
                end
            end
            if (i_cmd.shift || i_cmd.slot == SLOT_W'(WIN_DEPTH - 1)) begin
                n_win[WIN_DEPTH-1][l] = w_pin[l];
            end else begin
                n_win[WIN_DEPTH-1][l] = r_win[WIN_DEPTH-1][l];
            end
            for (int e = 0; e < WIN_DEPTH; e++) begin
                w_q[e][l] = DW'(n_win[e][l]);
            end
            n_a[l] = w_q[1][l] <<< 1;
            n_b[l] = w_q[2][l] - w_q[0][l];
            n_c[l] = (w_q[0][l] <<< 1) - (w_q[1][l] <<< 2) - w_q[1][l]
                   + (w_q[2][l] <<< 2) - w_q[3][l];
            n_d[l] = -w_q[0][l] + (w_q[1][l] <<< 1) + w_q[1][l]
                   - (w_q[2][l] <<< 1) - w_q[2][l] + w_q[3][l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int l = 0; l < 2; l++) begin
                for (int e = 0; e < WIN_DEPTH; e++) begin
                    r_win[e][l] <= n_win[e][l];
                end
                r_a[l] <= n_a[l];
                r_b[l] <= n_b[l];
                r_c[l] <= n_c[l];
                r_d[l] <= n_d[l];
            end
        end
    end

    assign w_tt0 = $signed({1'b0, i_cmd.t});
    assign w_tt1 = $signed({1'b0, r_t1});
    assign w_tt2 = $signed({1'b0, r_t2});

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_acc1[l] = AW'(r_c[l]) + AW'((r_m1[l] + HALF16) >>> T_WIDTH);
            w_acc2[l] = AW'(r_b[l]) + AW'((r_m2[l] + HALF16) >>> T_WIDTH);
            w_acc3[l] = AW'(r_a[l]) + AW'((r_m3[l] + HALF16) >>> T_WIDTH);
            w_half[l] = (w_acc3[l] + AW'(1)) >>> 1;
            if (w_half[l] > SAT_HI) begin
                w_sat[l] = W'(SAT_HI);
            end else if (w_half[l] < SAT_LO) begin
                w_sat[l] = W'(SAT_LO);
            end else begin
                w_sat[l] = W'(w_half[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t1    <= i_cmd.t;
            r_t2    <= r_t1;
            r_l1    <= i_cmd.last;
            r_l2    <= r_l1;
            r_l3    <= r_l2;
            for (int l = 0; l < 2; l++) begin
                r_m1[l] <= PW'(r_d[l]) * PW'(w_tt0);
                r_m2[l] <= PW'(w_acc1[l]) * PW'(w_tt1);
                r_m3[l] <= PW'(w_acc2[l]) * PW'(w_tt2);
            end
            r_ox    <= w_sat[0];
            r_oy    <= w_sat[1];
            r_olast <= r_l3;
        end
    end

    assign o_sample_valid    = r_ov;
    assign o_sample_x        = r_ox;
    assign o_sample_y        = r_oy;
    assign o_sample_run_last = r_olast;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable({r_v1, r_v2, r_v3, r_ov}))
        else $error("pipeline moved while stalled");

    a_load_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !(r_v1 || r_v2 || r_v3))
        else $error("coefficients reloaded with samples in flight");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the Catmull-Rom spline sampler. Feeds control point paths
// (directed corner cases, back-pressure and random paths under three idling
// profiles) and checks every sample against an internal fixed-point model of
// the window and the Horner evaluation.
// ----------------------------------------------------------------------------
module tb;
    import crss_pkg::*;

    localparam int MAX_SAMPLES     = 64;
    localparam int COORD_W         = 16;
    localparam int SETTLE_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } t_spline_sample;

    logic                        i_clk             = 1'b0;
    logic                        i_rst_n           = 1'b0;
    logic                        i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index       = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data        = '0;
    logic                        i_point_valid     = 1'b0;
    logic                        o_point_ready;
    logic signed [COORD_W-1:0]   i_point_x         = '0;
    logic signed [COORD_W-1:0]   i_point_y         = '0;
    logic                        i_point_path_end  = 1'b0;
    logic                        o_sample_valid;
    logic                        i_sample_ready    = 1'b0;
    logic signed [COORD_W-1:0]   o_sample_x;
    logic signed [COORD_W-1:0]   o_sample_y;
    logic                        o_sample_run_last;

    // model state
    logic [SAMPLES_W-1:0] model_samples = SAMPLES_RST;
    logic [STEP_W-1:0]    model_step    = STEP_RST;
    longint               win_x[WIN_DEPTH];
    longint               win_y[WIN_DEPTH];
    int                   win_held      = 0;
    t_spline_sample       pending_samples[$];

    int error_count    = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_off_asked = 0;
    int hold_off_seen  = 0;

    catmull_rom_spline_sampler_unit #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .COORD_WIDTH (COORD_W)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_point_valid     (i_point_valid),
        .o_point_ready     (o_point_ready),
        .i_point_x         (i_point_x),
        .i_point_y         (i_point_y),
        .i_point_path_end  (i_point_path_end),
        .o_sample_valid    (o_sample_valid),
        .i_sample_ready    (i_sample_ready),
        .o_sample_x        (o_sample_x),
        .o_sample_y        (o_sample_y),
        .o_sample_run_last (o_sample_run_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win_x[i] = 0;
            win_y[i] = 0;
        end
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [COORD_W-1:0] spline_coord(
        longint p0, longint p1, longint p2, longint p3, longint t
    );
        longint a;
        longint b;
        longint c;
        longint d;
        longint acc;
        a   = 2 * p1;
        b   = p2 - p0;
        c   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        d   = -p0 + 3 * p1 - 3 * p2 + p3;
        acc = d;
        acc = c + round_shift(acc * t, 16);
        acc = b + round_shift(acc * t, 16);
        acc = a + round_shift(acc * t, 16);
        acc = round_shift(acc, 1);
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return COORD_W'(acc);
    endfunction

    function automatic void predict_point(
        logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py, logic path_end
    );
        int             run_len;
        longint         t;
        t_spline_sample s;
        if (win_held < WIN_DEPTH) begin
            win_x[win_held] = px;
            win_y[win_held] = py;
            win_held++;
        end else begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                win_x[i] = win_x[i + 1];
                win_y[i] = win_y[i + 1];
            end
            win_x[WIN_DEPTH - 1] = px;
            win_y[WIN_DEPTH - 1] = py;
        end
        if (win_held == WIN_DEPTH) begin
            run_len = (model_samples > MAX_SAMPLES) ? MAX_SAMPLES : int'(model_samples);
            for (int k = 0; k < run_len; k++) begin
                t      = longint'((k * int'(model_step)) & 32'hFFFF);
                s.x    = spline_coord(win_x[0], win_x[1], win_x[2], win_x[3], t);
                s.y    = spline_coord(win_y[0], win_y[1], win_y[2], win_y[3], t);
                s.last = (k == run_len - 1);
                pending_samples = {pending_samples, s};
            end
        end
        if (path_end) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                win_x[i] = 0;
                win_y[i] = 0;
            end
            win_held = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sample checker and activity counter
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_spline_sample want;
        if (i_rst_n && o_sample_valid && i_sample_ready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected sample: x %0d y %0d last %0b",
                       o_sample_x, o_sample_y, o_sample_run_last);
                error_count++;
            end else begin
                want = pending_samples.pop_front();
                if (o_sample_x !== want.x) begin
                    $error("sample_x mismatch: expected %0d, got %0d", want.x, o_sample_x);
                    error_count++;
                end
                if (o_sample_y !== want.y) begin
                    $error("sample_y mismatch: expected %0d, got %0d", want.y, o_sample_y);
                    error_count++;
                end
                if (o_sample_run_last !== want.last) begin
                    $error("run_last mismatch: expected %0b, got %0b",
                           want.last, o_sample_run_last);
                    error_count++;
                end
            end
        end
        if (!i_rst_n || (i_point_valid && o_point_ready)
            || (o_sample_valid && i_sample_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_seen != hold_off_asked) begin
                hold_off_seen = hold_off_asked;
                i_sample_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_sample_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_point(
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic                      path_end
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_point_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_point_valid    <= 1'b1;
        i_point_x        <= px;
        i_point_y        <= py;
        i_point_path_end <= path_end;
        do @(posedge i_clk); while (!o_point_ready);
        predict_point(px, py, path_end);
    endtask

    // hold until every sample is out and the block has settled
    task automatic wait_idle();
        i_point_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_SAMPLES) begin
            model_samples = data[SAMPLES_W-1:0];
        end else if (idx == REG_STEP) begin
            model_step = data[STEP_W-1:0];
        end
    endtask

    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return COORD_W'(int'($urandom_range(200)) - 100);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_point(16'sh7FFF, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh0000, 16'sh0000, 1'b1);
    endtask

    task automatic test_short_paths();
        send_point(16'sd1, -16'sd1, 1'b1);
        send_point(16'sd100, 16'sd200, 1'b0);
        send_point(-16'sd100, -16'sd200, 1'b1);
        send_point(16'sd16384, -16'sd16384, 1'b0);
        send_point(-16'sd16384, 16'sd16384, 1'b0);
        send_point(16'sd5, 16'sd6, 1'b1);
        send_point(16'sd1000, -16'sd1000, 1'b0);
        send_point(16'sd3000, 16'sd2000, 1'b0);
        send_point(-16'sd7000, 16'sd9000, 1'b0);
        send_point(16'sd12000, -16'sd15000, 1'b1);
    endtask

    task automatic test_sample_counts();
        send_point(16'sd1000, 16'sd2000, 1'b0);
        send_point(-16'sd3000, 16'sd4000, 1'b0);
        send_point(16'sd8000, -16'sd8000, 1'b0);
        wait_idle();
        write_reg(REG_SAMPLES, 15'd0);
        send_point(16'sd12000, -16'sd12000, 1'b0);
        wait_idle();
        write_reg(REG_SAMPLES, 15'd1);
        send_point(-16'sd20000, 16'sd3, 1'b0);
        wait_idle();
        write_reg(REG_SAMPLES, 15'd2);
        send_point(16'sd32000, 16'sd31000, 1'b0);
        wait_idle();
        write_reg(REG_SAMPLES, 15'h7F83);
        send_point(-16'sd32000, -16'sd100, 1'b0);
        wait_idle();
        write_reg(REG_SAMPLES, 15'd127);
        write_reg(REG_STEP, 15'd1024);
        send_point(16'sd4096, 16'sd8192, 1'b0);
        wait_idle();
        write_reg(REG_SPARE_2, 15'h7FFF);
        write_reg(REG_SPARE_3, 15'h0001);
        send_point(-16'sd4096, 16'sd0, 1'b1);
    endtask

    task automatic test_step_wrap();
        wait_idle();
        write_reg(REG_SAMPLES, 15'd64);
        write_reg(REG_STEP, 15'h7FFF);
        send_point(16'sh7FFF, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7FFF, 1'b0);
        wait_idle();
        write_reg(REG_STEP, 15'd0);
        send_point(16'sd20000, 16'sd20000, 1'b0);
        wait_idle();
        write_reg(REG_STEP, 15'd1);
        send_point(-16'sd20000, 16'sd10000, 1'b0);
        wait_idle();
        write_reg(REG_STEP, 15'd21845);
        send_point(16'sd300, -16'sd300, 1'b1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(REG_SAMPLES, 15'd64);
        write_reg(REG_STEP, 15'd1024);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_asked++;
        for (int i = 0; i < 8; i++) begin
            send_point(random_coord(), random_coord(), i == 7);
        end
        wait_idle();
    endtask

    task automatic run_random_paths(input int item_total);
        int sent;
        int path_len;
        bit closes_path;
        sent = 0;
        while (sent < item_total) begin
            if ($urandom_range(99) < 15) begin
                path_len = $urandom_range(1, 3);
            end else begin
                path_len = $urandom_range(4, 10);
            end
            closes_path = ($urandom_range(9) != 0);
            for (int j = 0; j < path_len; j++) begin
                send_point(random_coord(), random_coord(), closes_path && (j == path_len - 1));
                sent++;
            end
        end
    endtask

    task automatic test_random();
        int run_len;
        wait_idle();
        write_reg(REG_SAMPLES, 15'd64);
        write_reg(REG_STEP, 15'd1024);
        send_idle_pct = 18;
        recv_idle_pct = 76;
        run_random_paths(65);

        wait_idle();
        write_reg(REG_SAMPLES, 15'd3);
        write_reg(REG_STEP, 15'd21845);
        send_idle_pct = 76;
        recv_idle_pct = 18;
        run_random_paths(65);

        wait_idle();
        run_len = $urandom_range(3, MAX_SAMPLES);
        write_reg(REG_SAMPLES, CFG_DATA_W'(run_len));
        write_reg(REG_STEP, CFG_DATA_W'((65536 + run_len / 2) / run_len));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_paths(65);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 18;
        recv_idle_pct = 76;
        test_reset_defaults();
        test_short_paths();
        test_sample_counts();
        test_step_wrap();
        test_backpressure();
        test_random();
        wait_idle();
        if (error_count == 0 && pending_samples.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
